// File: rtl/running_mean_variance_stats_assert.svh
// ----------------------------------------------------------------------------
// running mean / variance assertion macros
// concurrent checks sampled on clock, held off while reset is high
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEAN_VARIANCE_STATS_ASSERT_SVH
`define RUNNING_MEAN_VARIANCE_STATS_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define RMVS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RMVS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/rmvs_pkg.sv
// ----------------------------------------------------------------------------
// rmvs_pkg
// widths, codes and shared types of the running mean / variance block
// ----------------------------------------------------------------------------
package rmvs_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int COUNT_BITS     = 24;
   localparam int MEAN_FRAC_BITS = 16;

   // mean is a sample scaled up by the fraction bits
   localparam int MEAN_BITS      = SAMPLE_BITS + MEAN_FRAC_BITS;
   // deviation magnitude of a q-format sample from the mean
   localparam int DEV_BITS       = MEAN_BITS;

   localparam int SUM_BITS       = 64;
   localparam int VAR_BITS       = 40;
   localparam int VAR_FRAC_BITS  = 8;
   localparam int STD_BITS       = (VAR_BITS + VAR_FRAC_BITS) / 2;

   localparam int TERM_SHIFT     = 2 * MEAN_FRAC_BITS - VAR_FRAC_BITS;
   localparam int TERM_BITS      = 2 * DEV_BITS - TERM_SHIFT;

   // partial remainder of the shared divide / root unit
   localparam int REM_BITS       = (COUNT_BITS + 2 > STD_BITS + 3) ?
                                   COUNT_BITS + 2 : STD_BITS + 3;
   localparam int STEP_BITS      = $clog2(SUM_BITS + 1);

   localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = '1;

   localparam logic [STEP_BITS-1:0] STEPS_DIV_MEAN = STEP_BITS'(DEV_BITS);
   localparam logic [STEP_BITS-1:0] STEPS_DIV_VAR  = STEP_BITS'(SUM_BITS);
   localparam logic [STEP_BITS-1:0] STEPS_SQRT     = STEP_BITS'(STD_BITS);

   typedef enum logic [1:0] {
      ITER_DIV_MEAN,
      ITER_DIV_VAR,
      ITER_SQRT
   } iter_op_type;

   typedef struct packed {
      logic        start;
      iter_op_type op;
   } iter_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } iter_sts_type;

endpackage

// File: rtl/running_mean_variance_stats.sv
// ----------------------------------------------------------------------------
// running_mean_variance_stats
// running count, min, max, mean, variance and standard deviation of samples
// ----------------------------------------------------------------------------
// Each accepted sample updates the statistics by Welford's method in fixed
// point and gives one result beat with the count, min, max, mean (Q16.16),
// population variance (Q32.8, truncated, saturating) and the floor square
// root of the variance (Q16.8). Once a sample is accepted, req_ready stays
// low until its result is loaded into the result register, which may first
// wait for that register to empty. Once the count has saturated, the sample
// is ignored, full_res is set and the mean step is skipped. The single shared
// shift-subtract unit yields one bit per cycle: 32 for the mean step, 64 for
// the variance divide and 24 for the square root. The result register lets a
// new sample be taken while the last result is still held.
// ----------------------------------------------------------------------------
`include "running_mean_variance_stats_assert.svh"

module running_mean_variance_stats
   import rmvs_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [COUNT_BITS-1:0]        rsp_sample_count,
   output logic signed [SAMPLE_BITS-1:0] rsp_minimum,
   output logic signed [SAMPLE_BITS-1:0] rsp_maximum,
   output logic signed [MEAN_BITS-1:0]  rsp_mean,
   output logic [VAR_BITS-1:0]          rsp_variance,
   output logic [STD_BITS-1:0]          rsp_std_dev,
   output logic                         rsp_full_res
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MEAN_GO,
      S_MEAN_WAIT,
      S_DEV,
      S_MUL,
      S_ACC,
      S_VAR_GO,
      S_VAR_WAIT,
      S_SQRT_GO,
      S_SQRT_WAIT,
      S_OUT
   } state_type;

   state_type                    state_ff, state_in;

   // running statistics
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic signed [SAMPLE_BITS-1:0] min_ff, min_in;
   logic signed [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [MEAN_BITS-1:0]         mean_ff, mean_in;
   logic [SUM_BITS-1:0]          sum_ff, sum_in;

   // per-sample work registers
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic                         dev_neg_ff, dev_neg_in;
   logic [DEV_BITS-1:0]          dev_mag_ff, dev_mag_in;
   logic [DEV_BITS-1:0]          d2_mag_ff, d2_mag_in;
   logic [VAR_BITS-1:0]          var_ff, var_in;
   logic [STD_BITS-1:0]          std_ff, std_in;
   logic                         full_ff, full_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0]        rsp_count_ff, rsp_count_in;
   logic signed [SAMPLE_BITS-1:0] rsp_min_ff, rsp_min_in;
   logic signed [SAMPLE_BITS-1:0] rsp_max_ff, rsp_max_in;
   logic [MEAN_BITS-1:0]         rsp_mean_ff, rsp_mean_in;
   logic [VAR_BITS-1:0]          rsp_var_ff, rsp_var_in;
   logic [STD_BITS-1:0]          rsp_std_ff, rsp_std_in;
   logic                         rsp_full_ff, rsp_full_in;

   // shared unit hookup
   iter_ctl_type                 iter_ctl;
   iter_sts_type                 iter_sts;
   logic [SUM_BITS-1:0]          iter_operand;
   logic [SUM_BITS-1:0]          iter_result;
   logic [TERM_BITS-1:0]         term;

   // datapath helpers
   logic [MEAN_BITS:0]           mean_ext;
   logic [MEAN_BITS:0]           dev_req;
   logic [MEAN_BITS:0]           dev_req_abs;
   logic [MEAN_BITS:0]           d2_raw;
   logic [MEAN_BITS:0]           d2_abs;
   logic [MEAN_BITS:0]           q_ext;
   logic [MEAN_BITS:0]           q_step;
   logic [MEAN_BITS:0]           mean_sum;
   logic [SUM_BITS:0]            acc_sum;

   assign mean_ext = {mean_ff[MEAN_BITS-1], mean_ff};

   // delta = scaled sample - old mean, sign and magnitude
   assign dev_req     = {req_sample[SAMPLE_BITS-1], req_sample,
                         {MEAN_FRAC_BITS{1'b0}}} - mean_ext;
   assign dev_req_abs = dev_req[MEAN_BITS] ? (~dev_req + 1'b1) : dev_req;

   // scaled sample - new mean, same sign as delta or zero
   assign d2_raw = {x_ff[SAMPLE_BITS-1], x_ff, {MEAN_FRAC_BITS{1'b0}}} - mean_ext;
   assign d2_abs = d2_raw[MEAN_BITS] ? (~d2_raw + 1'b1) : d2_raw;

   // mean step: quotient truncated toward zero, carries the sign of delta
   assign q_ext    = {1'b0, iter_result[DEV_BITS-1:0]};
   assign q_step   = dev_neg_ff ? (~q_ext + 1'b1) : q_ext;
   assign mean_sum = mean_ext + q_step;

   // saturating accumulate of the squared deviation term
   assign acc_sum = {1'b0, sum_ff} + (SUM_BITS + 1)'(term);

   // operand for the shared unit, left aligned
   always_comb begin
      iter_ctl.start = 1'b0;
      iter_ctl.op    = ITER_DIV_VAR;
      iter_operand   = sum_ff;
      unique case (state_ff)
         S_MEAN_GO: begin
            iter_ctl.start = 1'b1;
            iter_ctl.op    = ITER_DIV_MEAN;
            iter_operand   = {dev_mag_ff, {(SUM_BITS - DEV_BITS){1'b0}}};
         end
         S_VAR_GO: begin
            iter_ctl.start = 1'b1;
            iter_ctl.op    = ITER_DIV_VAR;
            iter_operand   = sum_ff;
         end
         S_SQRT_GO: begin
            iter_ctl.start = 1'b1;
            iter_ctl.op    = ITER_SQRT;
            iter_operand   = {var_ff, {VAR_FRAC_BITS{1'b0}},
                              {(SUM_BITS - VAR_BITS - VAR_FRAC_BITS){1'b0}}};
         end
         default: begin
            iter_ctl.start = 1'b0;
         end
      endcase
   end

   rmvs_iter_unit u_iter (
      .clock    (clock),
      .reset    (reset),
      .iter_ctl (iter_ctl),
      .operand  (iter_operand),
      .divisor  (count_ff),
      .iter_sts (iter_sts),
      .result   (iter_result)
   );

   rmvs_dev_mult u_mult (
      .clock (clock),
      .dev_a (dev_mag_ff),
      .dev_b (d2_mag_ff),
      .term  (term)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      mean_in      = mean_ff;
      sum_in       = sum_ff;
      x_in         = x_ff;
      dev_neg_in   = dev_neg_ff;
      dev_mag_in   = dev_mag_ff;
      d2_mag_in    = d2_mag_ff;
      var_in       = var_ff;
      std_in       = std_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = rsp_count_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_var_in   = rsp_var_ff;
      rsp_std_in   = rsp_std_ff;
      rsp_full_in  = rsp_full_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_in = req_sample;
               if (count_ff == COUNT_LIMIT) begin
                  // saturated: sample dropped, statistics re-reported
                  full_in  = 1'b1;
                  state_in = S_VAR_GO;
               end else begin
                  full_in  = 1'b0;
                  count_in = count_ff + 1'b1;
                  if (count_ff == '0) begin
                     min_in = req_sample;
                     max_in = req_sample;
                  end else if (req_sample < min_ff) begin
                     min_in = req_sample;
                  end else if (req_sample > max_ff) begin
                     max_in = req_sample;
                  end
                  dev_neg_in = dev_req[MEAN_BITS];
                  dev_mag_in = dev_req_abs[DEV_BITS-1:0];
                  state_in   = S_MEAN_GO;
               end
            end
         end
         S_MEAN_GO: begin
            state_in = S_MEAN_WAIT;
         end
         S_MEAN_WAIT: begin
            if (iter_sts.done) begin
               mean_in  = mean_sum[MEAN_BITS-1:0];
               state_in = S_DEV;
            end
         end
         S_DEV: begin
            d2_mag_in = d2_abs[DEV_BITS-1:0];
            state_in  = S_MUL;
         end
         S_MUL: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            sum_in   = acc_sum[SUM_BITS] ? '1 : acc_sum[SUM_BITS-1:0];
            state_in = S_VAR_GO;
         end
         S_VAR_GO: begin
            state_in = S_VAR_WAIT;
         end
         S_VAR_WAIT: begin
            if (iter_sts.done) begin
               var_in   = (|iter_result[SUM_BITS-1:VAR_BITS]) ?
                          '1 : iter_result[VAR_BITS-1:0];
               state_in = S_SQRT_GO;
            end
         end
         S_SQRT_GO: begin
            state_in = S_SQRT_WAIT;
         end
         S_SQRT_WAIT: begin
            if (iter_sts.done) begin
               std_in   = iter_result[STD_BITS-1:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // load the result beat once the register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               rsp_min_in   = min_ff;
               rsp_max_in   = max_ff;
               rsp_mean_in  = mean_ff;
               rsp_var_in   = var_ff;
               rsp_std_in   = std_ff;
               rsp_full_in  = full_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      dev_neg_ff   <= dev_neg_in;
      dev_mag_ff   <= dev_mag_in;
      d2_mag_ff    <= d2_mag_in;
      var_ff       <= var_in;
      std_ff       <= std_in;
      full_ff      <= full_in;
      rsp_count_ff <= rsp_count_in;
      rsp_min_ff   <= rsp_min_in;
      rsp_max_ff   <= rsp_max_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_var_ff   <= rsp_var_in;
      rsp_std_ff   <= rsp_std_in;
      rsp_full_ff  <= rsp_full_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         mean_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         mean_ff      <= mean_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_count = rsp_count_ff;
   assign rsp_minimum      = rsp_min_ff;
   assign rsp_maximum      = rsp_max_ff;
   assign rsp_mean         = rsp_mean_ff;
   assign rsp_variance     = rsp_var_ff;
   assign rsp_std_dev      = rsp_std_ff;
   assign rsp_full_res     = rsp_full_ff;

   // checks
   `RMVS_ASSERT_NOW(a_busy_not_ready, iter_sts.busy, !req_ready,
      "sample taken while unit busy")
   `RMVS_ASSERT_NEXT(a_count_step,
      req_valid && req_ready && (count_ff != COUNT_LIMIT),
      count_ff == $past(count_ff) + 1'b1, "count did not advance on a sample")
   `RMVS_ASSERT_NOW(a_full_count, rsp_valid && rsp_full_res,
      rsp_sample_count == COUNT_LIMIT, "full beat without saturated count")
   `RMVS_ASSERT_NOW(a_min_le_max, rsp_valid && (rsp_sample_count != '0),
      rsp_minimum <= rsp_maximum, "minimum above maximum")

endmodule

// File: rtl/rmvs_iter_unit.sv
// ----------------------------------------------------------------------------
// rmvs_iter_unit
// shared shift / compare / subtract unit: one quotient or root bit per cycle
// ----------------------------------------------------------------------------
module rmvs_iter_unit
   import rmvs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  iter_ctl_type          iter_ctl,
   input  logic [SUM_BITS-1:0]   operand,
   input  logic [COUNT_BITS-1:0] divisor,
   output iter_sts_type          iter_sts,
   output logic [SUM_BITS-1:0]   result
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_BITS-1:0]  cnt_ff, cnt_in;
   iter_op_type           op_ff, op_in;
   logic [SUM_BITS-1:0]   src_ff, src_in;
   logic [REM_BITS-1:0]   rem_ff, rem_in;
   logic [SUM_BITS-1:0]   res_ff, res_in;
   logic [COUNT_BITS-1:0] dvs_ff, dvs_in;

   logic [REM_BITS-1:0]   rem_sh;
   logic [REM_BITS-1:0]   trial;
   logic [SUM_BITS-1:0]   src_sh;
   logic                  fits;
   logic [STEP_BITS-1:0]  steps;

   // root takes two radicand bits a step, division one
   always_comb begin
      if (op_ff == ITER_SQRT) begin
         rem_sh = {rem_ff[REM_BITS-3:0], src_ff[SUM_BITS-1 -: 2]};
         trial  = REM_BITS'({res_ff[STD_BITS-1:0], 2'b01});
         src_sh = src_ff << 2;
      end else begin
         rem_sh = {rem_ff[REM_BITS-2:0], src_ff[SUM_BITS-1]};
         trial  = REM_BITS'(dvs_ff);
         src_sh = src_ff << 1;
      end
      fits = (rem_sh >= trial);
   end

   always_comb begin
      unique case (iter_ctl.op)
         ITER_DIV_MEAN: steps = STEPS_DIV_MEAN;
         ITER_DIV_VAR:  steps = STEPS_DIV_VAR;
         ITER_SQRT:     steps = STEPS_SQRT;
         default:       steps = STEPS_DIV_VAR;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      src_in  = src_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      dvs_in  = dvs_ff;
      if (iter_ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         op_in   = iter_ctl.op;
         src_in  = operand;
         rem_in  = '0;
         res_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         src_in = src_sh;
         rem_in = fits ? (rem_sh - trial) : rem_sh;
         res_in = {res_ff[SUM_BITS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      op_ff  <= op_in;
      src_ff <= src_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign iter_sts.busy = busy_ff;
   assign iter_sts.done = done_ff;
   assign result        = res_ff;

endmodule

// File: rtl/rmvs_dev_mult.sv
// ----------------------------------------------------------------------------
// rmvs_dev_mult
// registered product of two deviation magnitudes, scaled down to q.8
// ----------------------------------------------------------------------------
module rmvs_dev_mult
   import rmvs_pkg::*;
(
   input  logic                 clock,
   input  logic [DEV_BITS-1:0]  dev_a,
   input  logic [DEV_BITS-1:0]  dev_b,
   output logic [TERM_BITS-1:0] term
);

   logic [2*DEV_BITS-1:0] prod;
   logic [TERM_BITS-1:0]  term_ff;

   assign prod = dev_a * dev_b;

   // truncating shift, the product never exceeds the term width
   always_ff @(posedge clock) begin
      term_ff <= prod[2*DEV_BITS-1:TERM_SHIFT];
   end

   assign term = term_ff;

endmodule
